/* hdl/shbt_pkg.sv */
// Shared types, codes and constants of the spatial hash bucket table.
package shbt_pkg;

  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_REMOVE   = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_ENTRY    = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  localparam logic [23:0] CELL_SIZE_RST = 24'd16384;
  localparam logic [31:0] HASH_MUL_X    = 32'd73856093;
  localparam logic [31:0] HASH_MUL_Y    = 32'd19349663;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        entity_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] found_id;
    logic [9:0]  bucket_index;
    logic        last;
  } out_item_t;

  // classified request handed from front to back; bucket is 16 bits, enough for up to 65536 cells
  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] entity_id;
    logic [15:0] bucket;
  } work_t;

  typedef enum logic [3:0] {
    F_IDLE, F_DIVX, F_FIXX, F_DIVY, F_FIXY, F_MUL, F_LDM, F_MOD, F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_CLEAR, B_IDLE, B_CNT, B_RD, B_CHK, B_EMIT
  } back_state_e;

endpackage

/* hdl/shbt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module shbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/shbt_fifo.sv */
// Small synchronous FIFO for request and result queues.
module shbt_fifo #(
  parameter type T     = logic [7:0],
  parameter int  DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T              mem [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

/* hdl/shbt_front.sv */
// Front end: accepts a request, floor-divides the position, hashes and reduces to a bucket.
module shbt_front #(
  parameter int NUM_CELLS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               push_i,
  output logic               full_o,
  input  shbt_pkg::in_item_t item_i,
  output logic               wq_push_o,
  input  logic               wq_full_i,
  output shbt_pkg::work_t    work_o
);

  import shbt_pkg::*;

  localparam int          L_W      = $clog2(NUM_CELLS);
  localparam logic [31:0] RECIP    = 32'(((64'd1 << (31 + L_W)) - 64'd1) / 64'(NUM_CELLS));
  localparam logic [31:0] NC32     = 32'(NUM_CELLS);
  localparam logic [17:0] NC18     = 18'(NUM_CELLS);
  localparam logic [17:0] SEXT_ADJ = 18'(((65'd1 << 64) - (65'd1 << 32)) % 65'(NUM_CELLS));

  front_state_e state_q, state_d;

  logic [23:0]        cell_size_q;
  logic [1:0]         op_q;
  logic [15:0]        id_q;
  logic signed [31:0] py_q;
  logic [63:0]        dvd_q;
  logic [5:0]         step_q;
  logic               neg_q;
  logic [23:0]        drem_q;
  logic [31:0]        quo_q;
  logic [31:0]        cx_q, cy_q, hx_q, hy_q;
  logic [63:0]        prod_q;
  logic [17:0]        rest_q;

  logic [23:0] den;
  logic [24:0] drem_sh;
  logic        dge;
  logic [24:0] drem_nx;
  logic [31:0] quo_fix;
  logic [31:0] hash;
  logic [31:0] qest, qn, diff;
  logic [17:0] r1, r2, r3, bkt;

  function automatic logic [31:0] mag(input logic signed [31:0] v);
    mag = v[31] ? (~v + 32'd1) : v;
  endfunction

  assign den     = (cell_size_q == '0) ? 24'd1 : cell_size_q;
  assign drem_sh = {drem_q, dvd_q[63]};
  assign dge     = (drem_sh >= {1'b0, den});
  assign drem_nx = dge ? (drem_sh - {1'b0, den}) : drem_sh;
  // floor: negative with remainder rounds down one more
  assign quo_fix = !neg_q ? quo_q : ((drem_q != '0) ? ~quo_q : (~quo_q + 32'd1));
  assign hash    = hx_q ^ hy_q;
  // reciprocal estimate undershoots the quotient by at most two
  assign qest    = 32'(prod_q >> (31 + L_W));
  assign qn      = qest * NC32;
  assign diff    = hash - qn;
  assign r1      = (rest_q >= NC18) ? (rest_q - NC18) : rest_q;
  assign r2      = (r1 >= NC18) ? (r1 - NC18) : r1;
  // fold in the upper word of the sign-extended hash
  assign r3      = r2 + (hash[31] ? SEXT_ADJ : 18'd0);
  assign bkt     = (r3 >= NC18) ? (r3 - NC18) : r3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= CELL_SIZE_RST;
    end else if (cfg_we_i) begin
      cell_size_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (push_i) state_d = F_DIVX;
      F_DIVX: if (step_q == '0) state_d = F_FIXX;
      F_FIXX: state_d = F_DIVY;
      F_DIVY: if (step_q == '0) state_d = F_FIXY;
      F_FIXY: state_d = F_MUL;
      F_MUL:  state_d = F_LDM;
      F_LDM:  state_d = F_MOD;
      F_MOD:  state_d = F_PUSH;
      F_PUSH: if (!wq_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    full_o    = (state_q != F_IDLE);
    wq_push_o = (state_q == F_PUSH);
    work_o.opcode    = op_q;
    work_o.entity_id = id_q;
    work_o.bucket    = bkt[15:0];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        if (push_i) begin
          op_q   <= item_i.opcode;
          id_q   <= item_i.entity_id;
          py_q   <= item_i.pos_y;
          dvd_q  <= {mag(item_i.pos_x), 32'd0};
          neg_q  <= item_i.pos_x[31];
          drem_q <= '0;
          step_q <= 6'd31;
        end
      end
      F_DIVX, F_DIVY: begin
        dvd_q  <= {dvd_q[62:0], 1'b0};
        drem_q <= drem_nx[23:0];
        quo_q  <= {quo_q[30:0], dge};
        step_q <= step_q - 6'd1;
      end
      F_FIXX: begin
        cx_q   <= quo_fix;
        dvd_q  <= {mag(py_q), 32'd0};
        neg_q  <= py_q[31];
        drem_q <= '0;
        step_q <= 6'd31;
      end
      F_FIXY: cy_q <= quo_fix;
      F_MUL: begin
        hx_q <= cx_q * HASH_MUL_X;
        hy_q <= cy_q * HASH_MUL_Y;
      end
      F_LDM: prod_q <= 64'(hash) * 64'(RECIP);
      F_MOD: rest_q <= diff[17:0];
      default: ;
    endcase
  end

endmodule

/* hdl/shbt_back.sv */
// Back end: owns the bucket counts and entries, carries out insert, remove and query.
module shbt_back #(
  parameter int NUM_CELLS  = 1024,
  parameter int BUCKET_CAP = 16,
  parameter int ID_BITS    = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wq_empty_i,
  output logic                wq_pop_o,
  input  shbt_pkg::work_t     work_i,
  output logic                res_push_o,
  input  logic                res_full_i,
  output shbt_pkg::out_item_t res_o,
  output logic                init_done_o
);

  import shbt_pkg::*;

  localparam int BKT_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int CNT_W = $clog2(BUCKET_CAP + 1);
  localparam int ENT_D = NUM_CELLS * BUCKET_CAP;
  localparam int EA_W  = (ENT_D > 1) ? $clog2(ENT_D) : 1;
  localparam logic [31:0] ID_MASK = 32'((64'd1 << ID_BITS) - 64'd1);

  back_state_e state_q, state_d;

  logic [BKT_W-1:0]   clr_q;
  logic [1:0]         op_q;
  logic [ID_BITS-1:0] id_q;
  logic [BKT_W-1:0]   bkt_q;
  logic [EA_W-1:0]    base_q;
  logic [CNT_W-1:0]   cnt_q, i_q, w_q;
  logic [2:0]         status_q;

  logic               cnt_we;
  logic [BKT_W-1:0]   cnt_waddr;
  logic [CNT_W-1:0]   cnt_wdata, cnt_rdata;
  logic               ent_we;
  logic [EA_W-1:0]    ent_waddr, ent_raddr;
  logic [ID_BITS-1:0] ent_wdata, ent_rdata;

  logic [31:0] id32, found32, bkt32;
  logic        is_last, ins_ok, hit;

  assign id32    = 32'(work_i.entity_id) & ID_MASK;
  assign found32 = 32'(ent_rdata);
  assign bkt32   = 32'(bkt_q);
  assign is_last = ((i_q + CNT_W'(1)) == cnt_q);
  assign ins_ok  = (op_q == OP_INSERT) && (status_q == ST_DONE);
  assign hit     = (ent_rdata == id_q);
  assign ent_raddr = base_q + EA_W'(i_q);

  shbt_ram #(.WIDTH(CNT_W), .DEPTH(NUM_CELLS)) u_counts (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (work_i.bucket[BKT_W-1:0]),
    .rdata_o (cnt_rdata)
  );

  shbt_ram #(.WIDTH(ID_BITS), .DEPTH(ENT_D)) u_entries (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) begin
        clr_q <= clr_q + BKT_W'(1);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_CLEAR: if (clr_q == BKT_W'(NUM_CELLS - 1)) state_d = B_IDLE;
      B_IDLE:  if (!wq_empty_i) state_d = B_CNT;
      B_CNT: begin
        if ((op_q == OP_REMOVE || op_q == OP_QUERY) && cnt_rdata != '0) begin
          state_d = B_RD;
        end else begin
          state_d = B_EMIT;
        end
      end
      B_RD: state_d = B_CHK;
      B_CHK: begin
        if (op_q == OP_REMOVE) begin
          state_d = is_last ? B_EMIT : B_RD;
        end else if (!res_full_i) begin
          state_d = is_last ? B_IDLE : B_RD;
        end
      end
      B_EMIT: if (!res_full_i) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    wq_pop_o    = (state_q == B_IDLE) && !wq_empty_i;
    init_done_o = (state_q != B_CLEAR);
    cnt_we      = 1'b0;
    cnt_waddr   = bkt_q;
    cnt_wdata   = '0;
    ent_we      = 1'b0;
    ent_waddr   = base_q + EA_W'(w_q);
    ent_wdata   = ent_rdata;
    res_push_o  = 1'b0;
    res_o.status       = status_q;
    res_o.found_id     = '0;
    res_o.bucket_index = bkt32[9:0];
    res_o.last         = 1'b1;
    case (state_q)
      B_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
      end
      B_CHK: begin
        if (op_q == OP_REMOVE) begin
          // compact: keep every slot that does not match
          ent_we = !hit;
        end else begin
          res_push_o     = !res_full_i;
          res_o.status   = ST_ENTRY;
          res_o.found_id = found32[15:0];
          res_o.last     = is_last;
        end
      end
      B_EMIT: begin
        res_push_o = !res_full_i;
        if (op_q == OP_REMOVE) begin
          cnt_we       = 1'b1;
          cnt_wdata    = w_q;
          res_o.status = (w_q == cnt_q) ? ST_NOTFOUND : ST_DONE;
        end else if (ins_ok) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_q + CNT_W'(1);
          ent_we    = 1'b1;
          ent_waddr = base_q + EA_W'(cnt_q);
          ent_wdata = id_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (!wq_empty_i) begin
          op_q   <= work_i.opcode;
          id_q   <= id32[ID_BITS-1:0];
          bkt_q  <= work_i.bucket[BKT_W-1:0];
          base_q <= EA_W'(work_i.bucket[BKT_W-1:0]) * EA_W'(BUCKET_CAP);
        end
      end
      B_CNT: begin
        cnt_q <= cnt_rdata;
        i_q   <= '0;
        w_q   <= '0;
        case (op_q)
          OP_INSERT: status_q <= (cnt_rdata < CNT_W'(BUCKET_CAP)) ? ST_DONE : ST_FULL;
          OP_QUERY:  status_q <= ST_EMPTY;
          default:   status_q <= ST_DONE;
        endcase
      end
      B_CHK: begin
        if (op_q == OP_REMOVE) begin
          if (!hit) begin
            w_q <= w_q + CNT_W'(1);
          end
          i_q <= i_q + CNT_W'(1);
        end else if (!res_full_i) begin
          i_q <= i_q + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

/* hdl/spatial_hash_bucket_table.sv */
// Top level of the spatial hash bucket table: front, request queue, back, result queue.
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+-------------------------
//  request   | in        | push / full         | in_item_i  (in_item_t)
//  result    | out       | empty / pop         | out_item_o (out_item_t)
//  config    | in        | cfg_we_i            | cfg_wdata_i (cell_size)
//
// Front works on one request at a time: two serial divisions by the cell size, each
// with a floor fix, then hash multiply, reciprocal multiply, remainder and hand-off.
// Back reads the bucket count, then an insert writes and emits; a remove reads and
// compacts each occupied slot, then emits; a query reads and emits each occupied slot.
// After reset the back clears the bucket counts, and full stays high until that is done.
// Either side may stall; two-deep queues sit between front, back and the result port.
module spatial_hash_bucket_table #(
  parameter int NUM_CELLS  = 1024,
  parameter int BUCKET_CAP = 16,
  parameter int ID_BITS    = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [23:0]         cfg_wdata_i,
  input  logic                push,
  output logic                full,
  input  shbt_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output shbt_pkg::out_item_t out_item_o
);

  import shbt_pkg::*;

  logic      init_done, front_full;
  logic      wq_push, wq_full, wq_pop, wq_empty;
  work_t     work_in, work_out;
  logic      res_push, res_full;
  out_item_t res;

  assign full = front_full || !init_done;

  shbt_front #(.NUM_CELLS(NUM_CELLS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push && init_done),
    .full_o      (front_full),
    .item_i      (in_item_i),
    .wq_push_o   (wq_push),
    .wq_full_i   (wq_full),
    .work_o      (work_in)
  );

  shbt_fifo #(.T(work_t), .DEPTH(2)) u_work_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (wq_push),
    .data_i  (work_in),
    .full_o  (wq_full),
    .pop_i   (wq_pop),
    .data_o  (work_out),
    .empty_o (wq_empty)
  );

  shbt_back #(
    .NUM_CELLS  (NUM_CELLS),
    .BUCKET_CAP (BUCKET_CAP),
    .ID_BITS    (ID_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wq_empty_i  (wq_empty),
    .wq_pop_o    (wq_pop),
    .work_i      (work_out),
    .res_push_o  (res_push),
    .res_full_i  (res_full),
    .res_o       (res),
    .init_done_o (init_done)
  );

  shbt_fifo #(.T(out_item_t), .DEPTH(2)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

`ifndef SYNTHESIS
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_done |-> full) else $error("request accepted during count clear");
  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full) else $error("result pushed into full queue");
  a_work_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wq_pop |-> !wq_empty) else $error("back popped an empty request queue");
`endif

endmodule

/* bench/shbt_checker.sv */
// Checker for the spatial hash bucket table: predicts results per request and compares.
`timescale 1ns / 1ps
module shbt_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [23:0]         cfg_wdata_i,
  input  logic                push,
  input  logic                full,
  input  shbt_pkg::in_item_t  in_item_i,
  input  logic                empty,
  input  logic                pop,
  input  shbt_pkg::out_item_t out_item_o,
  output int                  n_errors_o,
  output int                  n_pending_o
);
  import shbt_pkg::*;

  localparam int NCELLS = 1024;
  localparam int CAP    = 16;

  logic [23:0] cell_len;
  logic [15:0] slot_ids [NCELLS][CAP];
  int          slot_cnt [NCELLS];
  out_item_t   expected_q[$];

  function automatic logic signed [63:0] cell_coord(logic signed [31:0] p);
    logic signed [63:0] num, den, q, r;
    num = p;
    den = (cell_len == 0) ? 64'sd1 : $signed({40'd0, cell_len});
    q = num / den;
    r = num % den;
    if (r != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic [9:0] bucket_of(in_item_t it);
    logic [31:0] cx, cy, h;
    logic [63:0] wide;
    cx = 32'(cell_coord(it.pos_x));
    cy = 32'(cell_coord(it.pos_y));
    h = (cx * HASH_MUL_X) ^ (cy * HASH_MUL_Y);
    wide = {{32{h[31]}}, h};
    return 10'(wide % 64'(NCELLS));
  endfunction

  task automatic add_result(logic [2:0] st, logic [15:0] id, logic [9:0] b, logic lst);
    out_item_t r;
    r.status = st; r.found_id = id; r.bucket_index = b; r.last = lst;
    expected_q = {expected_q, r};
  endtask

  task automatic apply_request(in_item_t it);
    logic [9:0] b;
    int cnt, w;
    b = bucket_of(it);
    cnt = slot_cnt[b];
    case (it.opcode)
      OP_INSERT: begin
        if (cnt < CAP) begin
          slot_ids[b][cnt] = it.entity_id;
          slot_cnt[b] = cnt + 1;
          add_result(ST_DONE, 16'd0, b, 1'b1);
        end else begin
          add_result(ST_FULL, 16'd0, b, 1'b1);
        end
      end
      OP_REMOVE: begin
        w = 0;
        for (int i = 0; i < cnt; i++) begin
          if (slot_ids[b][i] != it.entity_id) begin
            slot_ids[b][w] = slot_ids[b][i];
            w++;
          end
        end
        slot_cnt[b] = w;
        add_result((w == cnt) ? ST_NOTFOUND : ST_DONE, 16'd0, b, 1'b1);
      end
      OP_QUERY: begin
        if (cnt == 0) add_result(ST_EMPTY, 16'd0, b, 1'b1);
        for (int i = 0; i < cnt; i++)
          add_result(ST_ENTRY, slot_ids[b][i], b, i + 1 == cnt);
      end
      default: add_result(ST_DONE, 16'd0, b, 1'b1);
    endcase
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_errors_o++;
  endtask

  initial begin
    n_errors_o = 0;
    n_pending_o = 0;
    cell_len = CELL_SIZE_RST;
    for (int i = 0; i < NCELLS; i++) slot_cnt[i] = 0;
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (cfg_we_i) cell_len <= cfg_wdata_i;
      if (push && !full) apply_request(in_item_i);
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, status", out_item_o.status, -1);
        end else begin
          want = expected_q.pop_front();
          if (out_item_o.status !== want.status)
            report_mismatch("status", out_item_o.status, want.status);
          if (out_item_o.found_id !== want.found_id)
            report_mismatch("found_id", out_item_o.found_id, want.found_id);
          if (out_item_o.bucket_index !== want.bucket_index)
            report_mismatch("bucket_index", out_item_o.bucket_index, want.bucket_index);
          if (out_item_o.last !== want.last)
            report_mismatch("last", out_item_o.last, want.last);
        end
      end
      n_pending_o = expected_q.size();
    end
  end
endmodule

/* bench/testbench.sv */
// Stimulus and verdict for the spatial hash bucket table.
`timescale 1ns / 1ps
module testbench;
  import shbt_pkg::*;

  localparam longint CYCLE_LIMIT = 2_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [23:0] cfg_wdata_i = '0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_item_o;
  int          n_errors, n_pending;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  int          hold_cycles = 0;
  longint      cycle_cnt = 0;

  // small pool of positions so that buckets are revisited and fill up
  logic signed [31:0] pos_pool_x[8], pos_pool_y[8];
  logic [15:0]        id_pool[6];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  spatial_hash_bucket_table u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .push, .full, .in_item_i,
    .empty, .pop, .out_item_o
  );

  shbt_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .push, .full, .in_item_i,
    .empty, .pop, .out_item_o, .n_errors_o(n_errors), .n_pending_o(n_pending)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stall, plus long hold-off counted here
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // push stays high after acceptance so that back-to-back requests drive it once per edge
  task automatic send_request(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // every accepted request is predicted at once, so nothing pending means nothing in flight
  task automatic drain_results();
    push <= 1'b0;
    @(negedge clk_i);
    while (n_pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_cell_size(logic [23:0] v);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_item_t make_req(logic [1:0] op, logic [15:0] id,
                                        logic signed [31:0] x, logic signed [31:0] y);
    in_item_t it;
    it.opcode = op; it.entity_id = id; it.pos_x = x; it.pos_y = y;
    return it;
  endfunction

  function automatic in_item_t random_req();
    in_item_t it;
    int k;
    k = $urandom_range(7);
    it.pos_x = ($urandom_range(9) < 8) ? pos_pool_x[k] : $urandom;
    it.pos_y = ($urandom_range(9) < 8) ? pos_pool_y[k] : $urandom;
    it.entity_id = ($urandom_range(9) < 7) ? id_pool[$urandom_range(5)] : 16'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3: it.opcode = OP_INSERT;
      4, 5:       it.opcode = OP_REMOVE;
      9:          it.opcode = OP_RESERVED;
      default:    it.opcode = OP_QUERY;
    endcase
    return it;
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_request(random_req());
  endtask

  initial begin
    logic signed [31:0] px;
    for (int i = 0; i < 8; i++) begin
      pos_pool_x[i] = $urandom;
      pos_pool_y[i] = $urandom;
    end
    for (int i = 0; i < 6; i++) id_pool[i] = 16'($urandom);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every opcode, fill a bucket past capacity
    px = 32'sd1000;
    send_request(make_req(OP_QUERY, 16'd0, px, px));
    send_request(make_req(OP_REMOVE, 16'd5, px, px));
    for (int i = 0; i < 17; i++)
      send_request(make_req(OP_INSERT, (i == 3) ? 16'hFFFF : 16'd7, px, px));
    send_request(make_req(OP_QUERY, 16'hFFFF, px, px));
    send_request(make_req(OP_REMOVE, 16'd7, px, px));
    send_request(make_req(OP_QUERY, 16'd0, px, px));
    send_request(make_req(OP_RESERVED, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    send_request(make_req(OP_INSERT, 16'd0, 32'h8000_0000, 32'h7FFF_FFFF));
    send_request(make_req(OP_INSERT, 16'd1, -32'sd1, 32'sd0));

    write_cell_size(24'd0);
    send_request(make_req(OP_INSERT, 16'd9, -32'sd3, 32'sd3));
    random_phase(30, 0, 0);
    write_cell_size(24'hFF_FFFF);
    random_phase(30, 85, 0);
    write_cell_size(24'd1);
    random_phase(30, 0, 85);
    write_cell_size(24'd256);
    random_phase(30, 31, 31);

    // long receiver hold-off while requests keep coming
    hold_cycles = 3000;
    random_phase(20, 0, 0);
    drain_results();
    write_cell_size(24'd16384);
    random_phase(40, 0, 0);
    random_phase(40, 31, 31);

    drain_results();
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
